// File: hdl/sas_pkg.sv
package sas_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int PTR_W       = ADDR_W + 2;

    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_CLEAR  = 2'd1;
    localparam logic [1:0] ACT_SORT   = 2'd2;
    localparam logic [1:0] ACT_SEARCH = 2'd3;

    localparam logic [1:0] ST_EMIT      = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

endpackage

// File: hdl/sorted_array_search_table.sv
// Append and clear are handled in idle. Table full: the result follows in the next cycle.
// Sort of N entries: exchange sort; each outer pass runs S_RD_I, S_GET_I, S_CMP for each
// later entry and S_WR_I, then setup in S_POST; emit runs S_E_RD and S_E_OUT per element.
// Search: same sort and setup, then S_B_CHK and S_B_CMP per probe, one more S_B_CHK on a miss.
// Results are one-cycle strobes on done; the receiver cannot stall them.
// Reset clears the entry count and control state; table contents are undefined until written.
module sorted_array_search_table (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          action,
    input  logic signed [31:0]  value,
    output logic                done,
    output logic [1:0]          status,
    output logic signed [31:0]  value_res,
    output logic [5:0]          index,
    output logic                last
);
    import sas_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_I, S_GET_I, S_CMP, S_WR_I, S_POST,
        S_E_RD, S_E_OUT, S_B_CHK, S_B_CMP
    } state_t;

    state_t                    state_reg;
    logic [1:0]                act_reg;
    logic signed [31:0]        key_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [ADDR_W-1:0]         i_reg;
    logic [ADDR_W-1:0]         j_reg;
    logic [ADDR_W-1:0]         mid_reg;
    logic signed [31:0]        a_reg;
    logic signed [PTR_W-1:0]   low_reg;
    logic signed [PTR_W-1:0]   high_reg;
    logic                      done_reg;
    logic [1:0]                status_reg;
    logic signed [31:0]        value_res_reg;
    logic [ADDR_W-1:0]         index_reg;
    logic                      last_reg;

    logic signed [31:0]        mem [MAX_ENTRIES];
    logic signed [31:0]        rdata_reg;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_wa;
    logic [ADDR_W-1:0]         mem_ra;
    logic signed [31:0]        mem_wd;

    logic signed [PTR_W-1:0]   mid_sum;
    logic                      swap;
    logic                      emit_last;

    assign mid_sum   = (low_reg + high_reg) >>> 1;
    assign swap      = a_reg > rdata_reg;
    assign emit_last = ({1'b0, j_reg} + CNT_W'(1)) == cnt_reg;

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = i_reg;
        mem_wd = a_reg;
        mem_ra = i_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && action == ACT_APPEND && cnt_reg < CNT_W'(MAX_ENTRIES))
                begin
                    mem_we = 1'b1;
                    mem_wa = cnt_reg[ADDR_W-1:0];
                    mem_wd = value;
                end
            end
            S_RD_I:  mem_ra = i_reg;
            S_GET_I: mem_ra = i_reg + ADDR_W'(1);
            S_CMP:
            begin
                mem_ra = j_reg + ADDR_W'(1);
                if (swap)
                begin
                    mem_we = 1'b1;
                    mem_wa = j_reg;
                end
            end
            S_WR_I:  mem_we = 1'b1;
            S_E_RD:  mem_ra = j_reg;
            S_B_CHK: mem_ra = mid_sum[ADDR_W-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_reg       <= ACT_APPEND;
            key_reg       <= '0;
            cnt_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            mid_reg       <= '0;
            a_reg         <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            done_reg      <= 1'b0;
            status_reg    <= ST_EMIT;
            value_res_reg <= '0;
            index_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        unique case (action)
                            ACT_APPEND:
                            begin
                                if (cnt_reg >= CNT_W'(MAX_ENTRIES))
                                begin
                                    done_reg      <= 1'b1;
                                    status_reg    <= ST_FULL;
                                    value_res_reg <= value;
                                    index_reg     <= '0;
                                    last_reg      <= 1'b1;
                                end
                                else
                                begin
                                    cnt_reg <= cnt_reg + CNT_W'(1);
                                end
                            end
                            ACT_CLEAR: cnt_reg <= '0;
                            default:
                            begin
                                act_reg   <= action;
                                key_reg   <= value;
                                i_reg     <= '0;
                                state_reg <= (cnt_reg >= CNT_W'(2)) ? S_RD_I : S_POST;
                            end
                        endcase
                    end
                end
                S_RD_I: state_reg <= S_GET_I;
                S_GET_I:
                begin
                    a_reg     <= rdata_reg;
                    j_reg     <= i_reg + ADDR_W'(1);
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (swap)
                    begin
                        a_reg <= rdata_reg;
                    end
                    if (({1'b0, j_reg} + CNT_W'(1)) < cnt_reg)
                    begin
                        j_reg <= j_reg + ADDR_W'(1);
                    end
                    else
                    begin
                        state_reg <= S_WR_I;
                    end
                end
                S_WR_I:
                begin
                    i_reg     <= i_reg + ADDR_W'(1);
                    state_reg <= (({1'b0, i_reg} + CNT_W'(2)) < cnt_reg) ? S_RD_I : S_POST;
                end
                S_POST:
                begin
                    if (act_reg == ACT_SORT)
                    begin
                        j_reg     <= '0;
                        state_reg <= (cnt_reg == '0) ? S_IDLE : S_E_RD;
                    end
                    else
                    begin
                        low_reg   <= '0;
                        high_reg  <= $signed({{(PTR_W-CNT_W){1'b0}}, cnt_reg}) - PTR_W'(1);
                        state_reg <= S_B_CHK;
                    end
                end
                S_E_RD: state_reg <= S_E_OUT;
                S_E_OUT:
                begin
                    done_reg      <= 1'b1;
                    status_reg    <= ST_EMIT;
                    value_res_reg <= rdata_reg;
                    index_reg     <= j_reg;
                    last_reg      <= emit_last;
                    j_reg         <= j_reg + ADDR_W'(1);
                    state_reg     <= emit_last ? S_IDLE : S_E_RD;
                end
                S_B_CHK:
                begin
                    if (low_reg <= high_reg)
                    begin
                        mid_reg   <= mid_sum[ADDR_W-1:0];
                        state_reg <= S_B_CMP;
                    end
                    else
                    begin
                        done_reg      <= 1'b1;
                        status_reg    <= ST_NOT_FOUND;
                        value_res_reg <= key_reg;
                        index_reg     <= '0;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_B_CMP:
                begin
                    if (rdata_reg == key_reg)
                    begin
                        done_reg      <= 1'b1;
                        status_reg    <= ST_FOUND;
                        value_res_reg <= key_reg;
                        index_reg     <= mid_reg;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else if (key_reg < rdata_reg)
                    begin
                        high_reg  <= $signed({2'b00, mid_reg}) - PTR_W'(1);
                        state_reg <= S_B_CHK;
                    end
                    else
                    begin
                        low_reg   <= $signed({2'b00, mid_reg}) + PTR_W'(1);
                        state_reg <= S_B_CHK;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign value_res = value_res_reg;
    assign index     = index_reg;
    assign last      = last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table size");

    a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP && mem_we) |-> (j_reg > i_reg))
        else $error("exchange write below outer index");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_EMIT) |-> last)
        else $error("single result without last");

    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without a request");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && last) |-> !busy)
        else $error("final result while still busy");

endmodule

// File: tb/sorted_array_search_table_checker.sv
`timescale 1ns / 1ps

module sorted_array_search_table_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         action,
    input  logic signed [31:0] value,
    input  logic               done,
    input  logic [1:0]         status,
    input  logic signed [31:0] value_res,
    input  logic [5:0]         index,
    input  logic               last,
    output int                 fail_count,
    output int                 pending,
    output int                 result_count
);
    import sas_pkg::*;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_res;
        logic [5:0]         index;
        logic               last;
    } table_result_t;

    logic signed [31:0] table_shadow [MAX_ENTRIES];
    int                 entry_total;
    table_result_t      expected_q [$];
    int                 errors_seen;
    int                 results_seen;

    task automatic sort_table_shadow();
        logic signed [31:0] swap_val;
        for (int i = 0; i < entry_total; i++)
        begin
            for (int j = i + 1; j < entry_total; j++)
            begin
                if (table_shadow[i] > table_shadow[j])
                begin
                    swap_val        = table_shadow[i];
                    table_shadow[i] = table_shadow[j];
                    table_shadow[j] = swap_val;
                end
            end
        end
    endtask

    task automatic predict_request(input logic [1:0] act, input logic signed [31:0] key);
        int lo;
        int hi;
        int mid;
        bit hit;
        if (act == ACT_APPEND)
        begin
            if (entry_total >= MAX_ENTRIES)
                expected_q.push_back(table_result_t'{ST_FULL, key, 6'd0, 1'b1});
            else
            begin
                table_shadow[entry_total] = key;
                entry_total++;
            end
        end
        else if (act == ACT_CLEAR)
            entry_total = 0;
        else
        begin
            sort_table_shadow();
            if (act == ACT_SORT)
            begin
                for (int i = 0; i < entry_total; i++)
                    expected_q.push_back(table_result_t'{ST_EMIT, table_shadow[i], 6'(i),
                                                         1'(i == entry_total - 1)});
            end
            else
            begin
                lo  = 0;
                hi  = entry_total - 1;
                mid = 0;
                hit = 1'b0;
                while (!hit && lo <= hi)
                begin
                    mid = (lo + hi) / 2;
                    if (table_shadow[mid] == key)
                        hit = 1'b1;
                    else if (key < table_shadow[mid])
                        hi = mid - 1;
                    else
                        lo = mid + 1;
                end
                if (hit)
                    expected_q.push_back(table_result_t'{ST_FOUND, key, 6'(mid), 1'b1});
                else
                    expected_q.push_back(table_result_t'{ST_NOT_FOUND, key, 6'd0, 1'b1});
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t got;
        table_result_t want;
        if (!rst_n)
        begin
            expected_q.delete();
            entry_total  = 0;
            errors_seen  = 0;
            results_seen = 0;
            fail_count   <= 0;
            pending      <= 0;
            result_count <= 0;
        end
        else
        begin
            if (done)
            begin
                got = table_result_t'{status, value_res, index, last};
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    errors_seen++;
                    if (errors_seen <= 10)
                        $display("ERROR: %0t unexpected result: status %0d value %0d index %0d last %0d",
                                 $realtime, got.status, got.value_res, got.index, got.last);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.status != want.status || got.value_res != want.value_res ||
                        got.index != want.index || got.last != want.last)
                    begin
                        errors_seen++;
                        if (errors_seen <= 10)
                        begin
                            $display("ERROR: %0t result mismatch", $realtime);
                            $display("  expected status %0d value %0d index %0d last %0d",
                                     want.status, want.value_res, want.index, want.last);
                            $display("  actual   status %0d value %0d index %0d last %0d",
                                     got.status, got.value_res, got.index, got.last);
                        end
                    end
                end
            end
            if (start && !busy)
                predict_request(action, value);
            fail_count   <= errors_seen;
            pending      <= expected_q.size();
            result_count <= results_seen;
        end
    end

endmodule

// File: tb/sorted_array_search_table_tb.sv
`timescale 1ns / 1ps

module sorted_array_search_table_tb;
    import sas_pkg::*;

    localparam int                 TOTAL_REQUESTS = 350;
    localparam int                 DRAIN_LIMIT    = 20000;
    localparam int                 TAIL_CYCLES    = 20;
    localparam logic signed [31:0] VAL_MIN        = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX        = 32'sh7FFF_FFFF;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         action;
    logic signed [31:0] value;
    logic               done;
    logic [1:0]         status;
    logic signed [31:0] value_res;
    logic [5:0]         index;
    logic               last;

    int                 fail_count;
    int                 pending;
    int                 result_count;

    logic signed [31:0] stored_vals [$];
    int                 request_total;
    int                 action_total [4];
    int                 full_hits;
    bit                 no_idle;

    sorted_array_search_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .value     (value),
        .done      (done),
        .status    (status),
        .value_res (value_res),
        .index     (index),
        .last      (last)
    );

    sorted_array_search_table_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .value        (value),
        .done         (done),
        .status       (status),
        .value_res    (value_res),
        .index        (index),
        .last         (last),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("ERROR: timeout, %0d results still expected", pending);
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_request(input logic [1:0] act, input logic signed [31:0] key);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        action <= act;
        value  <= key;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        request_total++;
        action_total[act]++;
        if (act == ACT_APPEND)
        begin
            if (stored_vals.size() < MAX_ENTRIES)
                stored_vals.push_back(key);
            else
                full_hits++;
        end
        else if (act == ACT_CLEAR)
            stored_vals.delete();
    endtask

    // small range gives plenty of duplicates
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3, 4: return int'($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_key();
        if (stored_vals.size() != 0 && $urandom_range(0, 9) < 6)
        begin
            if ($urandom_range(0, 4) == 0)
                return stored_vals[$urandom_range(0, stored_vals.size() - 1)] + 1;
            return stored_vals[$urandom_range(0, stored_vals.size() - 1)];
        end
        return pick_value();
    endfunction

    initial
    begin
        int drain_cycles;
        int extra;
        bit full_done;
        rst_n         = 1'b0;
        start         = 1'b0;
        action        = ACT_APPEND;
        value         = '0;
        request_total = 0;
        full_hits     = 0;
        full_done     = 1'b0;
        no_idle       = 1'b0;
        action_total  = '{default: 0};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, duplicates, misses, clear
        send_request(ACT_SORT, $urandom);
        send_request(ACT_SEARCH, 32'sd0);
        send_request(ACT_APPEND, VAL_MAX);
        send_request(ACT_APPEND, VAL_MIN);
        send_request(ACT_APPEND, 32'sd0);
        send_request(ACT_APPEND, -32'sd1);
        send_request(ACT_APPEND, 32'sd1);
        send_request(ACT_APPEND, 32'sd5);
        send_request(ACT_APPEND, 32'sd5);
        send_request(ACT_APPEND, 32'sh5555_5555);
        send_request(ACT_APPEND, 32'shAAAA_AAAA);
        send_request(ACT_SORT, $urandom);
        send_request(ACT_SEARCH, VAL_MIN);
        send_request(ACT_SEARCH, VAL_MAX);
        send_request(ACT_SEARCH, 32'sd5);
        send_request(ACT_SEARCH, 32'sd2);
        send_request(ACT_SEARCH, 32'shAAAA_AAAA);
        send_request(ACT_APPEND, 32'sd3);
        send_request(ACT_SEARCH, 32'sd3);
        send_request(ACT_CLEAR, $urandom);
        send_request(ACT_SORT, $urandom);
        send_request(ACT_SEARCH, 32'sd5);
        send_request(ACT_APPEND, -32'sd7);
        send_request(ACT_SORT, $urandom);
        send_request(ACT_SEARCH, -32'sd7);

        while (request_total < TOTAL_REQUESTS)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            if (!full_done || $urandom_range(0, 24) == 0)
            begin
                // fill to capacity, then overflow
                full_done = 1'b1;
                send_request(ACT_CLEAR, $urandom);
                while (stored_vals.size() < MAX_ENTRIES)
                    send_request(ACT_APPEND, pick_value());
                extra = $urandom_range(1, 3);
                repeat (extra)
                    send_request(ACT_APPEND, pick_value());
                send_request(ACT_SORT, $urandom);
                repeat (3)
                    send_request(ACT_SEARCH, pick_key());
                send_request(ACT_CLEAR, $urandom);
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    send_request(ACT_CLEAR, $urandom);
                extra = $urandom_range(0, 10);
                repeat (extra)
                    send_request(ACT_APPEND, pick_value());
                extra = $urandom_range(1, 4);
                repeat (extra)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: send_request(ACT_SORT, $urandom);
                        3:       send_request(ACT_APPEND, pick_value());
                        4:       send_request(2'($urandom_range(0, 3)), $urandom);
                        default: send_request(ACT_SEARCH, pick_key());
                    endcase
                end
            end
        end
        start <= 1'b0;

        drain_cycles = 0;
        @(posedge clk);
        while ((pending != 0 || busy) && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d requests: %0d append, %0d clear, %0d sort, %0d search",
                 request_total, action_total[ACT_APPEND], action_total[ACT_CLEAR],
                 action_total[ACT_SORT], action_total[ACT_SEARCH]);
        $display("%0d results checked, %0d appends hit a full table", result_count, full_hits);
        if (pending != 0)
            $display("ERROR: %0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
